@@ rtl/core/tie_pkg.sv @@
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and codes of the table interpolation engine.
// ----------------------------------------------------------------------------
package tie_pkg;

  // default sizing
  localparam int unsigned DefMaxNodes  = 64;
  localparam int unsigned DefMaxOrder  = 7;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned QueueDepth   = 4;

  // stream widths
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 40;

  // item opcodes
  typedef enum logic {
    OP_NODE_WR = 1'b0,
    OP_EVAL    = 1'b1
  } opcode_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_ORDER = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_e;

  // interpolation modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;

  // result status
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDIV = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // command carried from front to back
  typedef struct packed {
    opcode_e     op;
    logic [5:0]  slot;
    logic [31:0] opa;   // abscissa or query point
    logic [31:0] opb;   // ordinate
  } cmd_t;

endpackage

@@ rtl/core/tie_front.sv @@
// ----------------------------------------------------------------------------
// tie_front
// Accepts input transfers, sorts node writes from queries, drops writes to
// slots outside the table and pushes commands into the queue.
// ----------------------------------------------------------------------------
module tie_front import tie_pkg::*; #(
  parameter int unsigned MAX_NODES = DefMaxNodes
) (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,  // node_index, node_abscissa,
                                              // node_ordinate, query_x
  input  logic [0:0]         s_axis_tuser_i,  // opcode
  input  logic               q_full_i,
  output logic               q_push_o,
  output cmd_t               q_cmd_o
);

  logic       is_eval;
  logic [5:0] slot;
  logic       slot_ok;

  // decode fields
  assign is_eval = (s_axis_tuser_i[0] == OP_EVAL);
  assign slot    = s_axis_tdata_i[5:0];
  assign slot_ok = (32'(slot) < MAX_NODES);

  assign s_axis_tready_o = !q_full_i;

  // classify and push
  always_comb begin
    q_cmd_o.op   = is_eval ? OP_EVAL : OP_NODE_WR;
    q_cmd_o.slot = slot;
    q_cmd_o.opa  = is_eval ? s_axis_tdata_i[101:70] : s_axis_tdata_i[37:6];
    q_cmd_o.opb  = s_axis_tdata_i[69:38];
    q_push_o     = s_axis_tvalid_i && !q_full_i && (is_eval || slot_ok);
  end

endmodule

@@ rtl/core/tie_queue.sv @@
// ----------------------------------------------------------------------------
// tie_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tie_queue import tie_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/tie_back.sv @@
// ----------------------------------------------------------------------------
// tie_back
// Node tables, interval search, windowed Lagrange evaluation with a shared
// serial divider and multiplier, and the result register.
// ----------------------------------------------------------------------------
module tie_back import tie_pkg::*; #(
  parameter int unsigned MAX_NODES = DefMaxNodes,
  parameter int unsigned MAX_ORDER = DefMaxOrder,
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          interp_mode_i,
  input  logic [2:0]          poly_order_i,
  input  logic [6:0]          node_count_i,
  input  logic                q_empty_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // interp_value, left_slot
  output logic [1:0]          m_axis_tuser_o   // status
);

  localparam int unsigned AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NCW  = $clog2(MAX_NODES + 1);
  localparam int unsigned CW   = $clog2(MAX_ORDER + 2);
  localparam int unsigned NUMW = 33 + FRAC_BITS;
  localparam int unsigned DCW  = $clog2(NUMW + 1);
  localparam int unsigned SUMW = 32 + $clog2(MAX_ORDER + 2);
  localparam logic signed [31:0]   One   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0]   Rnd   = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [SUMW-1:0] SMax = SUMW'(32'sh7fff_ffff);
  localparam logic signed [SUMW-1:0] SMin = SUMW'(32'sh8000_0000);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CHK0  = 17'h00002,
    S_CHKN  = 17'h00004,
    S_SCAN  = 17'h00008,
    S_WIN   = 17'h00010,
    S_TERM  = 17'h00020,
    S_XI    = 17'h00040,
    S_KSEL  = 17'h00080,
    S_DSET  = 17'h00100,
    S_DIV   = 17'h00200,
    S_FAC   = 17'h00400,
    S_PMUL  = 17'h00800,
    S_PNORM = 17'h01000,
    S_YMUL  = 17'h02000,
    S_YNORM = 17'h04000,
    S_FIN   = 17'h08000,
    S_OUT   = 17'h10000
  } state_e;

  // truncate toward zero after dividing by one, then saturate; msb is the flag
  function automatic logic [32:0] norm_sat(logic signed [63:0] v);
    logic signed [63:0] adj;
    logic signed [63:0] sh;
    adj = v[63] ? (v + Rnd) : v;
    sh  = adj >>> FRAC_BITS;
    if (sh > 64'sd2147483647) begin
      norm_sat = {1'b1, 32'h7fff_ffff};
    end else if (sh < -64'sd2147483648) begin
      norm_sat = {1'b1, 32'h8000_0000};
    end else begin
      norm_sat = {1'b0, sh[31:0]};
    end
  endfunction

  state_e              state_q, state_d;
  logic [NCW-1:0]      n_q, n_d;
  logic signed [31:0]  xq_q, xq_d;
  logic [AW-1:0]       left_q, left_d;
  logic [NCW-1:0]      sc_q, sc_d;
  logic                cv_q, cv_d;
  logic [AW-1:0]       ci_q, ci_d;
  logic [AW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       cnt_q, cnt_d, i_q, i_d, k_q, k_d;
  logic signed [31:0]  xi_q, xi_d, yi_q, yi_d, p_q, p_d, r_q, r_d;
  logic signed [63:0]  prod_q, prod_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic                sat_q, sat_d;
  logic [32:0]         rem_q, rem_d, den_q, den_d;
  logic [NUMW-1:0]     quo_q, quo_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic                neg_q, neg_d;
  logic [31:0]         val_q, val_d;
  status_e             st_q, st_d;
  logic                mv_q, mv_d;
  logic [OutDataW-1:0] mdata_q, mdata_d;
  status_e             mst_q, mst_d;

  // tables
  logic [31:0]        xmem [MAX_NODES];
  logic [31:0]        ymem [MAX_NODES];
  logic signed [31:0] xr_q, yr_q;
  logic [AW-1:0]      raddr;
  logic               we;

  // window and arithmetic helpers
  logic [AW-1:0]      win_lo;
  logic [CW-1:0]      win_cnt;
  logic signed [32:0] dn, nm;
  logic [32:0]        dn_mag, nm_mag;
  logic [33:0]        trial;
  logic               ge;
  logic signed [31:0] mul_a, mul_b;
  logic [32:0]        ns;

  // table write from the queue head, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      xmem[AW'(q_cmd_i.slot)] <= q_cmd_i.opa;
      ymem[AW'(q_cmd_i.slot)] <= q_cmd_i.opb;
    end
    xr_q <= xmem[raddr];
    yr_q <= ymem[raddr];
  end

  // evaluation window from the bracketing node
  always_comb begin
    int n, l, c, m, lo;
    n = int'(n_q);
    l = int'(left_q);
    m = 0;
    if (interp_mode_i == MODE_LINEAR || (interp_mode_i == MODE_QUAD && n == 2)) begin
      c  = 2;
      lo = l;
    end else if (interp_mode_i == MODE_QUAD) begin
      c  = 3;
      lo = (l + 1 == n - 1) ? l - 1 : l;
    end else begin
      m = int'(poly_order_i);
      if (m < 1) m = 1;
      if (m > int'(MAX_ORDER)) m = int'(MAX_ORDER);
      if (m > n - 1) m = n - 1;
      c  = m + 1;
      lo = l - c / 2;
      if (lo < 0) lo = 0;
      if (lo + c - 1 > n - 1) lo = n - c;
    end
    win_lo  = AW'(lo);
    win_cnt = CW'(c);
  end

  // divider step and operand magnitudes
  assign dn     = {xi_q[31], xi_q} - {xr_q[31], xr_q};
  assign nm     = {xq_q[31], xq_q} - {xr_q[31], xr_q};
  assign dn_mag = dn[32] ? 33'(-dn) : 33'(dn);
  assign nm_mag = nm[32] ? 33'(-nm) : 33'(nm);
  assign trial  = {rem_q, quo_q[NUMW-1]};
  assign ge     = (trial >= {1'b0, den_q});

  // shared multiplier operands
  assign mul_a = (state_q == S_YMUL) ? yi_q : p_q;
  assign mul_b = (state_q == S_YMUL) ? p_q : r_q;
  assign ns    = norm_sat(prod_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d = n_q;  xq_d = xq_q;  left_d = left_q;
    sc_d = sc_q;  cv_d = cv_q;  ci_d = ci_q;
    lo_d = lo_q;  cnt_d = cnt_q;  i_d = i_q;  k_d = k_q;
    xi_d = xi_q;  yi_d = yi_q;  p_d = p_q;  r_d = r_q;
    prod_d = prod_q;  sum_d = sum_q;  sat_d = sat_q;
    rem_d = rem_q;  den_d = den_q;  quo_d = quo_q;  dcnt_d = dcnt_q;  neg_d = neg_q;
    val_d = val_q;  st_d = st_q;
    mv_d = mv_q;  mdata_d = mdata_q;  mst_d = mst_q;
    raddr   = '0;
    we      = 1'b0;
    q_pop_o = 1'b0;

    // output register drains on a transfer
    if (mv_q && m_axis_tready_i) begin
      mv_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.op == OP_NODE_WR) begin
            we = 1'b1;
          end else begin
            xq_d = q_cmd_i.opa;
            if (node_count_i == 7'd0) begin
              n_d = NCW'(1);
            end else if (32'(node_count_i) > MAX_NODES) begin
              n_d = NCW'(MAX_NODES);
            end else begin
              n_d = NCW'(node_count_i);
            end
            state_d = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        raddr = AW'(n_q - 1'b1);
        if (n_q == NCW'(1)) begin
          val_d   = yr_q;
          left_d  = '0;
          st_d    = ST_OK;
          state_d = S_OUT;
        end else if (xq_q <= xr_q) begin
          left_d  = '0;
          state_d = S_WIN;
        end else begin
          state_d = S_CHKN;
        end
      end
      S_CHKN: begin
        if (xq_q >= xr_q) begin
          left_d  = AW'(n_q - NCW'(2));
          state_d = S_WIN;
        end else begin
          left_d  = '0;
          sc_d    = '0;
          cv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      // one node per cycle, compare in the cycle after the read
      S_SCAN: begin
        raddr = sc_q[AW-1:0];
        if (cv_q && xr_q <= xq_q) begin
          left_d = ci_q;
        end
        cv_d = (sc_q <= n_q - NCW'(2));
        ci_d = sc_q[AW-1:0];
        sc_d = sc_q + 1'b1;
        if (cv_q && ci_q == AW'(n_q - NCW'(2))) begin
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        lo_d    = win_lo;
        cnt_d   = win_cnt;
        i_d     = '0;
        sum_d   = '0;
        sat_d   = 1'b0;
        state_d = S_TERM;
      end
      S_TERM: begin
        raddr   = AW'(lo_q + AW'(i_q));
        state_d = S_XI;
      end
      S_XI: begin
        xi_d    = xr_q;
        yi_d    = yr_q;
        p_d     = One;
        k_d     = '0;
        state_d = S_KSEL;
      end
      S_KSEL: begin
        if (k_q == cnt_q) begin
          state_d = S_YMUL;
        end else if (k_q == i_q) begin
          k_d = k_q + 1'b1;
        end else begin
          raddr   = AW'(lo_q + AW'(k_q));
          state_d = S_DSET;
        end
      end
      // equal abscissae end the query at once
      S_DSET: begin
        if (dn == '0) begin
          val_d   = '0;
          st_d    = ST_ZDIV;
          state_d = S_OUT;
        end else begin
          rem_d   = '0;
          quo_d   = NUMW'(nm_mag) << FRAC_BITS;
          den_d   = dn_mag;
          neg_d   = nm[32] ^ dn[32];
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      S_DIV: begin
        rem_d  = ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
        quo_d  = {quo_q[NUMW-2:0], ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(NUMW - 1)) begin
          state_d = S_FAC;
        end
      end
      S_FAC: begin
        if (neg_q) begin
          if (quo_q > NUMW'(32'h8000_0000)) begin
            r_d   = 32'sh8000_0000;
            sat_d = 1'b1;
          end else begin
            r_d = 32'(-quo_q[31:0]);
          end
        end else if (quo_q > NUMW'(32'h7fff_ffff)) begin
          r_d   = 32'sh7fff_ffff;
          sat_d = 1'b1;
        end else begin
          r_d = quo_q[31:0];
        end
        state_d = S_PMUL;
      end
      S_PMUL: begin
        prod_d  = 64'(mul_a) * 64'(mul_b);
        state_d = S_PNORM;
      end
      S_PNORM: begin
        p_d     = ns[31:0];
        sat_d   = sat_q | ns[32];
        k_d     = k_q + 1'b1;
        state_d = S_KSEL;
      end
      S_YMUL: begin
        prod_d  = 64'(mul_a) * 64'(mul_b);
        state_d = S_YNORM;
      end
      S_YNORM: begin
        sum_d   = sum_q + SUMW'($signed(ns[31:0]));
        sat_d   = sat_q | ns[32];
        i_d     = i_q + 1'b1;
        state_d = (i_q == cnt_q - 1'b1) ? S_FIN : S_TERM;
      end
      S_FIN: begin
        if (sum_q > SMax) begin
          val_d = 32'h7fff_ffff;
          st_d  = ST_SAT;
        end else if (sum_q < SMin) begin
          val_d = 32'h8000_0000;
          st_d  = ST_SAT;
        end else begin
          val_d = sum_q[31:0];
          st_d  = sat_q ? ST_SAT : ST_OK;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          mdata_d = OutDataW'({6'(left_q), val_q});
          mst_d   = st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mv_q    <= 1'b0;
      cv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
      cv_q    <= cv_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    n_q <= n_d;  xq_q <= xq_d;  left_q <= left_d;
    sc_q <= sc_d;  ci_q <= ci_d;
    lo_q <= lo_d;  cnt_q <= cnt_d;  i_q <= i_d;  k_q <= k_d;
    xi_q <= xi_d;  yi_q <= yi_d;  p_q <= p_d;  r_q <= r_d;
    prod_q <= prod_d;  sum_q <= sum_d;  sat_q <= sat_d;
    rem_q <= rem_d;  den_q <= den_d;  quo_q <= quo_d;  dcnt_q <= dcnt_d;  neg_q <= neg_d;
    val_q <= val_d;  st_q <= st_d;
    mdata_q <= mdata_d;  mst_q <= mst_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = mst_q;

endmodule

@@ rtl/core/table_interpolation_engine_unit.sv @@
// ----------------------------------------------------------------------------
// table_interpolation_engine_unit
// Node table with linear, quadratic and windowed Lagrange interpolation.
// ----------------------------------------------------------------------------
// usage
//   slave stream: tuser[0] is the opcode; a node write stores abscissa and
//   ordinate in a slot and gives no result, a query gives one result
//   master stream: tdata holds value and left slot, tuser holds status
//   apb port: interp_mode at 0x0, poly_order at 0x4, node_count at 0x8
// sequence
//   a node write is stored in the back in the same cycle it leaves the queue
//   a query checks the end nodes, scans the interval only when the point lies
//   between them, then per window node reads the node and per factor runs the
//   one-bit-per-cycle divider and the shared multiplier, then adds the term;
//   a window of c nodes has c*(c-1) factors
//   a four-entry queue lets the slave side keep accepting during a query
// reset
//   queue and result register empty, registers at mode 0, order 1, count 1;
//   table contents are undefined until written
// stall
//   a result waits in the output register; the back holds its next result
//   and the queue fills, then tready drops
module table_interpolation_engine_unit import tie_pkg::*; #(
  parameter int unsigned MAX_NODES = DefMaxNodes,
  parameter int unsigned MAX_ORDER = DefMaxOrder,
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // node_index, node_abscissa,
                                               // node_ordinate, query_x
  input  logic [0:0]          s_axis_tuser_i,  // opcode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // interp_value, left_slot
  output logic [1:0]          m_axis_tuser_o,  // status
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0] mode_q, mode_d;
  logic [2:0] order_q, order_d;
  logic [6:0] count_q, count_d;
  logic       wr_en;
  reg_idx_e   idx;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       push_cmd, head_cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // register writes and reads
  always_comb begin
    mode_d  = mode_q;
    order_d = order_q;
    count_d = count_q;
    prdata  = '0;
    unique case (idx)
      REG_MODE: begin
        prdata = 32'(mode_q);
        if (wr_en) mode_d = pwdata[1:0];
      end
      REG_ORDER: begin
        prdata = 32'(order_q);
        if (wr_en) order_d = pwdata[2:0];
      end
      REG_COUNT: begin
        prdata = 32'(count_q);
        if (wr_en) count_d = pwdata[6:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      order_q <= 3'd1;
      count_q <= 7'd1;
    end else begin
      mode_q  <= mode_d;
      order_q <= order_d;
      count_q <= count_d;
    end
  end

  // front: accept and classify
  tie_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  // command queue
  tie_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .cmd_o  (head_cmd)
  );

  // back: tables and evaluation
  tie_back #(
    .MAX_NODES(MAX_NODES),
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .interp_mode_i  (mode_q),
    .poly_order_i   (order_q),
    .node_count_i   (count_q),
    .q_empty_i      (q_empty),
    .q_cmd_i        (head_cmd),
    .q_pop_o        (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule
